// ----- sv/i2cm_pkg.sv -----
// Shared types and constants for the I2C master transaction engine.
package i2cm_pkg;

   // Data byte counter width
   localparam int CountBits = 8;

   // Depth of the queue between the front and the sequencer
   localparam int QueueDepth = 2;
   localparam int QueuePtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntBits = $clog2(QueueDepth + 1);

   // Bit position of the byte MSB, shifted out first
   localparam int ByteMsb = 7;

   // Request codes on req_type
   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_BEGIN = 2'd1;
   localparam logic [1:0] REQ_DATA  = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_ADDR_NACK = 2'd1;
   localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

   // Classified command
   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_BEGIN,
      CMD_DATA,
      CMD_NOP
   } cmd_type;

   // Bus sequencer phase
   typedef enum logic [4:0] {
      PH_IDLE, PH_ST_SDA_HI, PH_ST_SCL_HI, PH_ST_SDA_LO, PH_ST_SCL_LO,
      PH_WB_SET, PH_WB_HI, PH_WB_LO, PH_ACK_REL, PH_ACK_HI, PH_ACK_LO,
      PH_WAIT, PH_RB_REL, PH_RB_HI, PH_RB_LO, PH_RB_ACK, PH_RB_AHI,
      PH_RB_ALO, PH_SP_SDA_LO, PH_SP_SCL_HI, PH_SP_SDA_HI
   } phase_type;

   // One queued word
   typedef struct packed {
      cmd_type    cmd;
      logic [6:0] dev_addr;
      logic       read_not_write;
      logic [7:0] byte_count;
      logic [7:0] write_byte;
      logic       sda_in;
   } item_type;

endpackage

// ----- sv/i2cm_front.sv -----
// Front end: classifies incoming words and queues them for the sequencer.
module i2cm_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_type,
   input  logic [6:0]         req_dev_addr,
   input  logic               req_read_not_write,
   input  logic [7:0]         req_byte_count,
   input  logic [7:0]         req_write_byte,
   input  logic               req_sda_in,
   output logic               q_valid,
   output i2cm_pkg::item_type q_item,
   input  logic               q_pop
);

   i2cm_pkg::item_type                       entry_ff [i2cm_pkg::QueueDepth];
   logic [i2cm_pkg::QueuePtrBits-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [i2cm_pkg::QueuePtrBits-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [i2cm_pkg::QueueCntBits-1:0]        count_ff, count_in;
   i2cm_pkg::item_type                       item_in;
   logic                                     push;
   logic                                     pop;

   // Classify the request code
   always_comb begin
      item_in.dev_addr       = req_dev_addr;
      item_in.read_not_write = req_read_not_write;
      item_in.byte_count     = req_byte_count;
      item_in.write_byte     = req_write_byte;
      item_in.sda_in         = req_sda_in;
      case (req_type)
         i2cm_pkg::REQ_TICK:  item_in.cmd = i2cm_pkg::CMD_TICK;
         i2cm_pkg::REQ_BEGIN: item_in.cmd = i2cm_pkg::CMD_BEGIN;
         i2cm_pkg::REQ_DATA:  item_in.cmd = i2cm_pkg::CMD_DATA;
         default:             item_in.cmd = i2cm_pkg::CMD_NOP;
      endcase
   end

   assign req_ready = (count_ff != i2cm_pkg::QueueCntBits'(i2cm_pkg::QueueDepth));
   assign q_valid   = (count_ff != '0);
   assign q_item    = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_pop && q_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == i2cm_pkg::QueuePtrBits'(i2cm_pkg::QueueDepth - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == i2cm_pkg::QueuePtrBits'(i2cm_pkg::QueueDepth - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the word
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule

// ----- sv/i2cm_back.sv -----
// Back end: I2C bus sequencer and registered result word.
module i2cm_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  i2cm_pkg::item_type q_item,
   output logic               q_pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_scl,
   output logic               rsp_sda_out,
   output logic               rsp_sda_drive,
   output logic               rsp_need_data,
   output logic               rsp_read_valid,
   output logic [7:0]         rsp_read_byte,
   output logic               rsp_done_res,
   output logic [1:0]         rsp_status,
   output logic               rsp_busy_res
);

   i2cm_pkg::phase_type             phase_ff, phase_in;
   logic [3:0]                      bit_index_ff, bit_index_in;
   logic [7:0]                      shift_ff, shift_in;
   logic [i2cm_pkg::CountBits-1:0]  bytes_left_ff, bytes_left_in;
   logic                            is_read_ff, is_read_in;
   logic [1:0]                      status_ff, status_in;
   logic                            scl_ff, scl_in;
   logic                            sda_ff, sda_in;
   logic                            drive_ff, drive_in;
   logic                            addr_byte_ff, addr_byte_in;
   logic                            rvalid;
   logic [7:0]                      rbyte;
   logic                            done;
   logic                            step;
   logic                            is_tick;
   logic [3:0]                      bit_next;

   // Output word register
   logic                            out_valid_ff;
   logic                            out_scl_ff, out_sda_ff, out_drive_ff;
   logic                            out_need_ff, out_rvalid_ff, out_done_ff, out_busy_ff;
   logic [7:0]                      out_rbyte_ff;
   logic [1:0]                      out_status_ff;

   assign step     = q_valid && (!out_valid_ff || rsp_ready);
   assign q_pop    = step;
   assign is_tick  = (q_item.cmd == i2cm_pkg::CMD_TICK);
   assign bit_next = bit_index_ff + 4'd1;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (q_item.cmd)
            i2cm_pkg::CMD_BEGIN: begin
               if (phase_ff == i2cm_pkg::PH_IDLE) phase_in = i2cm_pkg::PH_ST_SDA_HI;
            end
            i2cm_pkg::CMD_DATA: begin
               if (phase_ff == i2cm_pkg::PH_WAIT) phase_in = i2cm_pkg::PH_WB_SET;
            end
            i2cm_pkg::CMD_TICK: begin
               case (phase_ff)
                  i2cm_pkg::PH_IDLE:      phase_in = i2cm_pkg::PH_IDLE;
                  i2cm_pkg::PH_WAIT:      phase_in = i2cm_pkg::PH_WAIT;
                  i2cm_pkg::PH_ST_SDA_HI: phase_in = i2cm_pkg::PH_ST_SCL_HI;
                  i2cm_pkg::PH_ST_SCL_HI: phase_in = i2cm_pkg::PH_ST_SDA_LO;
                  i2cm_pkg::PH_ST_SDA_LO: phase_in = i2cm_pkg::PH_ST_SCL_LO;
                  i2cm_pkg::PH_ST_SCL_LO: phase_in = i2cm_pkg::PH_WB_SET;
                  i2cm_pkg::PH_WB_SET:    phase_in = i2cm_pkg::PH_WB_HI;
                  i2cm_pkg::PH_WB_HI:     phase_in = i2cm_pkg::PH_WB_LO;
                  i2cm_pkg::PH_WB_LO:
                     phase_in = bit_next[3] ? i2cm_pkg::PH_ACK_REL : i2cm_pkg::PH_WB_SET;
                  i2cm_pkg::PH_ACK_REL:   phase_in = i2cm_pkg::PH_ACK_HI;
                  i2cm_pkg::PH_ACK_HI:    phase_in = i2cm_pkg::PH_ACK_LO;
                  i2cm_pkg::PH_ACK_LO: begin
                     if (status_ff != i2cm_pkg::STATUS_OK || bytes_left_ff == '0) begin
                        phase_in = i2cm_pkg::PH_SP_SDA_LO;
                     end else if (is_read_ff) begin
                        phase_in = i2cm_pkg::PH_RB_REL;
                     end else begin
                        phase_in = i2cm_pkg::PH_WAIT;
                     end
                  end
                  i2cm_pkg::PH_RB_REL:    phase_in = i2cm_pkg::PH_RB_HI;
                  i2cm_pkg::PH_RB_HI:     phase_in = i2cm_pkg::PH_RB_LO;
                  i2cm_pkg::PH_RB_LO:
                     phase_in = bit_next[3] ? i2cm_pkg::PH_RB_ACK : i2cm_pkg::PH_RB_HI;
                  i2cm_pkg::PH_RB_ACK:    phase_in = i2cm_pkg::PH_RB_AHI;
                  i2cm_pkg::PH_RB_AHI:    phase_in = i2cm_pkg::PH_RB_ALO;
                  i2cm_pkg::PH_RB_ALO:
                     phase_in = (bytes_left_ff == '0) ? i2cm_pkg::PH_SP_SDA_LO
                                                      : i2cm_pkg::PH_RB_REL;
                  i2cm_pkg::PH_SP_SDA_LO: phase_in = i2cm_pkg::PH_SP_SCL_HI;
                  i2cm_pkg::PH_SP_SCL_HI: phase_in = i2cm_pkg::PH_SP_SDA_HI;
                  i2cm_pkg::PH_SP_SDA_HI: phase_in = i2cm_pkg::PH_IDLE;
                  default:                phase_in = i2cm_pkg::PH_IDLE;
               endcase
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Datapath and pin outputs
   always_comb begin
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      bytes_left_in = bytes_left_ff;
      is_read_in    = is_read_ff;
      status_in     = status_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      drive_in      = drive_ff;
      addr_byte_in  = addr_byte_ff;
      rvalid        = 1'b0;
      rbyte         = '0;
      done          = 1'b0;
      if (step && q_item.cmd == i2cm_pkg::CMD_BEGIN && phase_ff == i2cm_pkg::PH_IDLE) begin
         is_read_in    = q_item.read_not_write;
         shift_in      = {q_item.dev_addr, q_item.read_not_write};
         bytes_left_in = i2cm_pkg::CountBits'(q_item.byte_count);
         status_in     = i2cm_pkg::STATUS_OK;
         bit_index_in  = '0;
         addr_byte_in  = 1'b1;
      end
      if (step && q_item.cmd == i2cm_pkg::CMD_DATA && phase_ff == i2cm_pkg::PH_WAIT) begin
         shift_in      = q_item.write_byte;
         bytes_left_in = bytes_left_ff - 1'b1;
         bit_index_in  = '0;
      end
      if (step && is_tick) begin
         case (phase_ff)
            i2cm_pkg::PH_ST_SDA_HI: begin
               sda_in   = 1'b1;
               drive_in = 1'b1;
            end
            i2cm_pkg::PH_ST_SCL_HI: scl_in = 1'b1;
            i2cm_pkg::PH_ST_SDA_LO: sda_in = 1'b0;
            i2cm_pkg::PH_ST_SCL_LO: begin
               scl_in       = 1'b0;
               bit_index_in = '0;
            end
            i2cm_pkg::PH_WB_SET: begin
               sda_in   = shift_ff[i2cm_pkg::ByteMsb];
               drive_in = 1'b1;
            end
            i2cm_pkg::PH_WB_HI: scl_in = 1'b1;
            i2cm_pkg::PH_WB_LO: begin
               scl_in       = 1'b0;
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_index_in = bit_next;
            end
            i2cm_pkg::PH_ACK_REL: drive_in = 1'b0;
            i2cm_pkg::PH_ACK_HI: begin
               scl_in = 1'b1;
               if (q_item.sda_in) begin
                  status_in = addr_byte_ff ? i2cm_pkg::STATUS_ADDR_NACK
                                           : i2cm_pkg::STATUS_DATA_NACK;
               end
            end
            i2cm_pkg::PH_ACK_LO: begin
               scl_in       = 1'b0;
               drive_in     = 1'b1;
               addr_byte_in = 1'b0;
            end
            i2cm_pkg::PH_RB_REL: begin
               drive_in     = 1'b0;
               bit_index_in = '0;
               shift_in     = '0;
            end
            i2cm_pkg::PH_RB_HI: begin
               scl_in   = 1'b1;
               shift_in = {shift_ff[6:0], q_item.sda_in};
            end
            i2cm_pkg::PH_RB_LO: begin
               scl_in       = 1'b0;
               bit_index_in = bit_next;
            end
            i2cm_pkg::PH_RB_ACK: begin
               drive_in      = 1'b1;
               sda_in        = (bytes_left_ff == i2cm_pkg::CountBits'(1));
               rvalid        = 1'b1;
               rbyte         = shift_ff;
               bytes_left_in = bytes_left_ff - 1'b1;
            end
            i2cm_pkg::PH_RB_AHI: scl_in = 1'b1;
            i2cm_pkg::PH_RB_ALO: scl_in = 1'b0;
            i2cm_pkg::PH_SP_SDA_LO: begin
               sda_in   = 1'b0;
               drive_in = 1'b1;
            end
            i2cm_pkg::PH_SP_SCL_HI: scl_in = 1'b1;
            i2cm_pkg::PH_SP_SDA_HI: begin
               sda_in = 1'b1;
               done   = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= i2cm_pkg::PH_IDLE;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         bytes_left_ff <= '0;
         is_read_ff    <= 1'b0;
         status_ff     <= i2cm_pkg::STATUS_OK;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         drive_ff      <= 1'b1;
         addr_byte_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         bytes_left_ff <= bytes_left_in;
         is_read_ff    <= is_read_in;
         status_ff     <= status_in;
         scl_ff        <= scl_in;
         sda_ff        <= sda_in;
         drive_ff      <= drive_in;
         addr_byte_ff  <= addr_byte_in;
      end
   end

   // Hold the result word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_scl_ff    <= scl_in;
         out_sda_ff    <= sda_in;
         out_drive_ff  <= drive_in;
         out_need_ff   <= (phase_in == i2cm_pkg::PH_WAIT);
         out_rvalid_ff <= rvalid;
         out_rbyte_ff  <= rbyte;
         out_done_ff   <= done;
         out_status_ff <= status_in;
         out_busy_ff   <= (phase_in != i2cm_pkg::PH_IDLE);
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_scl        = out_scl_ff;
   assign rsp_sda_out    = out_sda_ff;
   assign rsp_sda_drive  = out_drive_ff;
   assign rsp_need_data  = out_need_ff;
   assign rsp_read_valid = out_rvalid_ff;
   assign rsp_read_byte  = out_rbyte_ff;
   assign rsp_done_res   = out_done_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_busy_res   = out_busy_ff;

endmodule

// ----- sv/i2c_master_transaction_engine_unit.sv -----
// Top level of the I2C master transaction engine.
//
// Runs whole I2C master transactions one pin step per word: a begin word
// latches address, direction and byte count, each tick word advances the
// bus by one step (START, address and R/W, ACK, data bytes, STOP), and a
// data word supplies the next write byte when need_data is set. Every
// accepted word returns exactly one result word with the pin levels after
// that step. The engine takes one word per clock while results are taken:
// a two-entry queue sits between the request decode and the bus sequencer,
// and the sequencer executes one queued word per clock into an output
// register, unless that register holds a result not yet taken. With
// rsp_ready held low the queue and output register absorb up to three
// words before req_ready drops.
module i2c_master_transaction_engine_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [6:0] req_dev_addr,
   input  logic       req_read_not_write,
   input  logic [7:0] req_byte_count,
   input  logic [7:0] req_write_byte,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_sda_drive,
   output logic       rsp_need_data,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic       rsp_done_res,
   output logic [1:0] rsp_status,
   output logic       rsp_busy_res
);

   logic               q_valid;
   logic               q_pop;
   i2cm_pkg::item_type q_item;

   // Decode and queue
   i2cm_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_dev_addr       (req_dev_addr),
      .req_read_not_write (req_read_not_write),
      .req_byte_count     (req_byte_count),
      .req_write_byte     (req_write_byte),
      .req_sda_in         (req_sda_in),
      .q_valid            (q_valid),
      .q_item             (q_item),
      .q_pop              (q_pop)
   );

   // Bus sequencer
   i2cm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_scl        (rsp_scl),
      .rsp_sda_out    (rsp_sda_out),
      .rsp_sda_drive  (rsp_sda_drive),
      .rsp_need_data  (rsp_need_data),
      .rsp_read_valid (rsp_read_valid),
      .rsp_read_byte  (rsp_read_byte),
      .rsp_done_res   (rsp_done_res),
      .rsp_status     (rsp_status),
      .rsp_busy_res   (rsp_busy_res)
   );

endmodule

// ----- tb/testbench.sv -----
// Testbench for the I2C master transaction engine: directed and random bus steps.
`timescale 1ns / 100ps

module testbench;

   // Request code with no meaning to the engine
   localparam logic [1:0] REQ_NOP = 2'd3;

   localparam int RandomWords = 1150;
   localparam int HoldCycles = 80;
   localparam int DrainCycles = 12;
   localparam int CycleLimit = 400000;

   // Pin levels and flags expected after one word
   typedef struct {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       need_data;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       done_res;
      logic [1:0] status;
      logic       busy_res;
   } pin_step_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [1:0] req_type = i2cm_pkg::REQ_TICK;
   logic [6:0] req_dev_addr = '0;
   logic       req_read_not_write = 1'b0;
   logic [7:0] req_byte_count = '0;
   logic [7:0] req_write_byte = '0;
   logic       req_sda_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_scl;
   logic       rsp_sda_out;
   logic       rsp_sda_drive;
   logic       rsp_need_data;
   logic       rsp_read_valid;
   logic [7:0] rsp_read_byte;
   logic       rsp_done_res;
   logic [1:0] rsp_status;
   logic       rsp_busy_res;

   // Bus sequencer state as predicted
   i2cm_pkg::phase_type bus_phase;
   logic [3:0] bus_bit;
   logic [7:0] bus_shift;
   logic [7:0] bus_bytes_left;
   logic       bus_is_read;
   logic [1:0] bus_status;
   logic       bus_scl;
   logic       bus_sda;
   logic       bus_drive;
   logic       bus_addr_byte;

   pin_step_type pin_steps_due[$];
   int         error_count = 0;
   int         cycle_count = 0;
   int         bus_words = 0;
   bit         send_burst = 1'b0;
   bit         drain_burst = 1'b0;
   bit         hold_request = 1'b0;

   i2c_master_transaction_engine_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_type           (req_type),
      .req_dev_addr       (req_dev_addr),
      .req_read_not_write (req_read_not_write),
      .req_byte_count     (req_byte_count),
      .req_write_byte     (req_write_byte),
      .req_sda_in         (req_sda_in),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl            (rsp_scl),
      .rsp_sda_out        (rsp_sda_out),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_need_data      (rsp_need_data),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status),
      .rsp_busy_res       (rsp_busy_res)
   );

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   task automatic report_error(input string msg);
      $display("[%0t] ERROR %s", $time, msg);
      error_count++;
   endtask

   task automatic reset_bus_model();
      bus_phase = i2cm_pkg::PH_IDLE;
      bus_bit = '0;
      bus_shift = '0;
      bus_bytes_left = '0;
      bus_is_read = 1'b0;
      bus_status = i2cm_pkg::STATUS_OK;
      bus_scl = 1'b1;
      bus_sda = 1'b1;
      bus_drive = 1'b1;
      bus_addr_byte = 1'b0;
   endtask

   // Advance the predicted sequencer by one accepted word and queue its result
   task automatic step_bus_model(input logic [1:0] kind, input logic [6:0] addr,
                                 input logic rnw, input logic [7:0] count,
                                 input logic [7:0] wbyte, input logic sda);
      pin_step_type due;
      due.read_valid = 1'b0;
      due.read_byte = '0;
      due.done_res = 1'b0;
      case (kind)
         i2cm_pkg::REQ_BEGIN: begin
            if (bus_phase == i2cm_pkg::PH_IDLE) begin
               bus_is_read = rnw;
               bus_shift = {addr, rnw};
               bus_bytes_left = count;
               bus_status = i2cm_pkg::STATUS_OK;
               bus_bit = '0;
               bus_addr_byte = 1'b1;
               bus_phase = i2cm_pkg::PH_ST_SDA_HI;
            end
         end
         i2cm_pkg::REQ_DATA: begin
            if (bus_phase == i2cm_pkg::PH_WAIT) begin
               bus_shift = wbyte;
               bus_bytes_left = bus_bytes_left - 8'd1;
               bus_bit = '0;
               bus_phase = i2cm_pkg::PH_WB_SET;
            end
         end
         i2cm_pkg::REQ_TICK: begin
            case (bus_phase)
               i2cm_pkg::PH_ST_SDA_HI: begin
                  bus_sda = 1'b1;
                  bus_drive = 1'b1;
                  bus_phase = i2cm_pkg::PH_ST_SCL_HI;
               end
               i2cm_pkg::PH_ST_SCL_HI: begin
                  bus_scl = 1'b1;
                  bus_phase = i2cm_pkg::PH_ST_SDA_LO;
               end
               i2cm_pkg::PH_ST_SDA_LO: begin
                  bus_sda = 1'b0;
                  bus_phase = i2cm_pkg::PH_ST_SCL_LO;
               end
               i2cm_pkg::PH_ST_SCL_LO: begin
                  bus_scl = 1'b0;
                  bus_bit = '0;
                  bus_phase = i2cm_pkg::PH_WB_SET;
               end
               i2cm_pkg::PH_WB_SET: begin
                  bus_sda = bus_shift[7];
                  bus_drive = 1'b1;
                  bus_phase = i2cm_pkg::PH_WB_HI;
               end
               i2cm_pkg::PH_WB_HI: begin
                  bus_scl = 1'b1;
                  bus_phase = i2cm_pkg::PH_WB_LO;
               end
               i2cm_pkg::PH_WB_LO: begin
                  bus_scl = 1'b0;
                  bus_shift = bus_shift << 1;
                  bus_bit = bus_bit + 4'd1;
                  bus_phase = (bus_bit >= 4'd8) ? i2cm_pkg::PH_ACK_REL
                                                : i2cm_pkg::PH_WB_SET;
               end
               i2cm_pkg::PH_ACK_REL: begin
                  bus_drive = 1'b0;
                  bus_phase = i2cm_pkg::PH_ACK_HI;
               end
               i2cm_pkg::PH_ACK_HI: begin
                  bus_scl = 1'b1;
                  if (sda)
                     bus_status = bus_addr_byte ? i2cm_pkg::STATUS_ADDR_NACK
                                                : i2cm_pkg::STATUS_DATA_NACK;
                  bus_phase = i2cm_pkg::PH_ACK_LO;
               end
               i2cm_pkg::PH_ACK_LO: begin
                  bus_scl = 1'b0;
                  bus_drive = 1'b1;
                  bus_addr_byte = 1'b0;
                  if (bus_status != i2cm_pkg::STATUS_OK || bus_bytes_left == 8'd0)
                     bus_phase = i2cm_pkg::PH_SP_SDA_LO;
                  else if (bus_is_read)
                     bus_phase = i2cm_pkg::PH_RB_REL;
                  else
                     bus_phase = i2cm_pkg::PH_WAIT;
               end
               i2cm_pkg::PH_RB_REL: begin
                  bus_drive = 1'b0;
                  bus_bit = '0;
                  bus_shift = '0;
                  bus_phase = i2cm_pkg::PH_RB_HI;
               end
               i2cm_pkg::PH_RB_HI: begin
                  bus_scl = 1'b1;
                  bus_shift = {bus_shift[6:0], sda};
                  bus_phase = i2cm_pkg::PH_RB_LO;
               end
               i2cm_pkg::PH_RB_LO: begin
                  bus_scl = 1'b0;
                  bus_bit = bus_bit + 4'd1;
                  bus_phase = (bus_bit >= 4'd8) ? i2cm_pkg::PH_RB_ACK
                                                : i2cm_pkg::PH_RB_HI;
               end
               i2cm_pkg::PH_RB_ACK: begin
                  bus_drive = 1'b1;
                  bus_sda = (bus_bytes_left == 8'd1);
                  due.read_valid = 1'b1;
                  due.read_byte = bus_shift;
                  bus_bytes_left = bus_bytes_left - 8'd1;
                  bus_phase = i2cm_pkg::PH_RB_AHI;
               end
               i2cm_pkg::PH_RB_AHI: begin
                  bus_scl = 1'b1;
                  bus_phase = i2cm_pkg::PH_RB_ALO;
               end
               i2cm_pkg::PH_RB_ALO: begin
                  bus_scl = 1'b0;
                  bus_phase = (bus_bytes_left == 8'd0) ? i2cm_pkg::PH_SP_SDA_LO
                                                       : i2cm_pkg::PH_RB_REL;
               end
               i2cm_pkg::PH_SP_SDA_LO: begin
                  bus_sda = 1'b0;
                  bus_drive = 1'b1;
                  bus_phase = i2cm_pkg::PH_SP_SCL_HI;
               end
               i2cm_pkg::PH_SP_SCL_HI: begin
                  bus_scl = 1'b1;
                  bus_phase = i2cm_pkg::PH_SP_SDA_HI;
               end
               i2cm_pkg::PH_SP_SDA_HI: begin
                  bus_sda = 1'b1;
                  due.done_res = 1'b1;
                  bus_phase = i2cm_pkg::PH_IDLE;
               end
               i2cm_pkg::PH_IDLE, i2cm_pkg::PH_WAIT: ;
               default: bus_phase = i2cm_pkg::PH_IDLE;
            endcase
         end
         default: ;
      endcase
      due.scl = bus_scl;
      due.sda_out = bus_sda;
      due.sda_drive = bus_drive;
      due.need_data = (bus_phase == i2cm_pkg::PH_WAIT);
      due.status = bus_status;
      due.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
      pin_steps_due.push_back(due);
   endtask

   // Offer one word after a random gap and hold it until accepted
   task automatic send_word(input logic [1:0] kind, input logic [6:0] addr, input logic rnw,
                            input logic [7:0] count, input logic [7:0] wbyte,
                            input logic sda);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_dev_addr <= addr;
      req_read_not_write <= rnw;
      req_byte_count <= count;
      req_write_byte <= wbyte;
      req_sda_in <= sda;
      do @(posedge clock); while (!req_ready);
      step_bus_model(kind, addr, rnw, count, wbyte, sda);
   endtask

   task automatic send_tick(input logic sda);
      send_word(i2cm_pkg::REQ_TICK, $urandom, $urandom, $urandom, $urandom, sda);
   endtask

   // Send a word the engine should ignore in its current phase
   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_word(i2cm_pkg::REQ_BEGIN, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
         1: send_word(REQ_NOP, $urandom, $urandom, $urandom, $urandom, $urandom);
         default: begin
            if (bus_phase == i2cm_pkg::PH_WAIT)
               send_tick($urandom);
            else
               send_word(i2cm_pkg::REQ_DATA, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
         end
      endcase
   endtask

   // Run one transaction from begin to STOP, with NACK odds per ACK slot
   task automatic run_transaction(input logic [6:0] addr, input logic rnw,
                                  input logic [7:0] count, input int addr_nack_pct,
                                  input int data_nack_pct, input int noise_pct);
      logic sda;
      send_word(i2cm_pkg::REQ_BEGIN, addr, rnw, count, $urandom, $urandom);
      bus_words++;
      while (bus_phase != i2cm_pkg::PH_IDLE) begin
         if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) begin
            send_noise();
         end else begin
            if (bus_phase == i2cm_pkg::PH_WAIT) begin
               send_word(i2cm_pkg::REQ_DATA, $urandom, $urandom, $urandom, $urandom,
                         $urandom);
            end else begin
               sda = $urandom_range(0, 1);
               if (bus_phase == i2cm_pkg::PH_ACK_HI)
                  sda = ($urandom_range(0, 99) <
                         (bus_addr_byte ? addr_nack_pct : data_nack_pct));
               send_tick(sda);
            end
            bus_words++;
         end
      end
   endtask

   // Check one result word against the oldest expectation
   task automatic check_field(input string name, input logic [7:0] got,
                              input logic [7:0] want);
      if (got !== want)
         report_error($sformatf("%s: got %0h expected %0h", name, got, want));
   endtask

   task automatic check_pin_step();
      pin_step_type want;
      if (pin_steps_due.size() == 0) begin
         report_error("result word with no word pending");
         return;
      end
      want = pin_steps_due.pop_front();
      check_field("scl", rsp_scl, want.scl);
      check_field("sda_out", rsp_sda_out, want.sda_out);
      check_field("sda_drive", rsp_sda_drive, want.sda_drive);
      check_field("need_data", rsp_need_data, want.need_data);
      check_field("read_valid", rsp_read_valid, want.read_valid);
      check_field("read_byte", rsp_read_byte, want.read_byte);
      check_field("done_res", rsp_done_res, want.done_res);
      check_field("status", rsp_status, want.status);
      check_field("busy_res", rsp_busy_res, want.busy_res);
   endtask

   // Accept result words, stalling at random or for a long hold when asked
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            check_pin_step();
            stall_left = drain_burst ? 0 : $urandom_range(0, 9);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HoldCycles;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Idle words: ticks, unknown codes and stray data change nothing
   task automatic test_idle_words();
      send_tick(1'b0);
      send_tick(1'b1);
      send_word(REQ_NOP, 7'h7F, 1'b1, 8'hFF, 8'hFF, 1'b1);
      send_word(i2cm_pkg::REQ_DATA, 7'h00, 1'b0, 8'h00, 8'hFF, 1'b0);
      send_word(i2cm_pkg::REQ_DATA, 7'h7F, 1'b1, 8'hFF, 8'h00, 1'b1);
   endtask

   // Zero byte count: address, ACK, then STOP with ok
   task automatic test_zero_count();
      run_transaction(7'h00, 1'b0, 8'd0, 0, 0, 0);
      run_transaction(7'h7F, 1'b1, 8'd0, 0, 0, 0);
   endtask

   // Address NACK ends a long read or write right after the address
   task automatic test_address_nack();
      run_transaction(7'h7F, 1'b1, 8'd255, 100, 0, 0);
      run_transaction(7'h00, 1'b0, 8'd255, 100, 0, 0);
   endtask

   task automatic test_write_data();
      run_transaction(7'h2A, 1'b0, 8'd3, 0, 0, 0);
   endtask

   // Data NACK aborts a write with bytes still left
   task automatic test_data_nack();
      run_transaction(7'h55, 1'b0, 8'd255, 0, 100, 0);
   endtask

   // Read: ACK after all bytes but the last, NACK on the last
   task automatic test_read_data();
      run_transaction(7'h13, 1'b1, 8'd1, 0, 0, 0);
      run_transaction(7'h6C, 1'b1, 8'd3, 0, 0, 0);
   endtask

   // Begin while busy, stray data and unknown codes mid-transaction
   task automatic test_busy_noise();
      run_transaction($urandom, 1'b0, 8'd2, 0, 0, 30);
      run_transaction($urandom, 1'b1, 8'd2, 0, 0, 30);
   endtask

   // Hold off the receiver while words keep coming back to back
   task automatic test_backpressure();
      send_burst = 1'b1;
      hold_request = 1'b1;
      run_transaction($urandom, 1'b0, 8'd1, 0, 0, 0);
      send_burst = 1'b0;
   endtask

   // Random transactions, mostly short, some long ones cut by NACK
   task automatic test_random_traffic();
      logic       rnw;
      logic [7:0] count;
      int         addr_pct;
      int         data_pct;
      bus_words = 0;
      while (bus_words < RandomWords) begin
         send_burst = ($urandom_range(0, 4) == 0);
         drain_burst = ($urandom_range(0, 4) == 0);
         rnw = $urandom_range(0, 1);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
         addr_pct = (count > 8'd6 && rnw) ? 100 : 10;
         data_pct = (count > 8'd6) ? 40 : 8;
         run_transaction($urandom, rnw, count, addr_pct, data_pct,
                         ($urandom_range(0, 2) == 0) ? 8 : 0);
      end
      send_burst = 1'b0;
      drain_burst = 1'b0;
   endtask

   // Reset, run each test in turn, drain and judge
   initial begin
      reset_bus_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_idle_words();
      test_zero_count();
      test_address_nack();
      test_write_data();
      test_data_nack();
      test_read_data();
      test_busy_noise();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pin_steps_due.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- files.f -----
sv/i2cm_pkg.sv
sv/i2cm_front.sv
sv/i2cm_back.sv
sv/i2c_master_transaction_engine_unit.sv
tb/testbench.sv
